/* hdl/bht_pkg.sv */
package bht_pkg;

	localparam logic [31:0] HASH_MULT = 32'd1327217885;
	localparam int unsigned HASH_STEP = 5; // k*33 = (k << 5) + k

	typedef enum logic [2:0] {
		ST_INSERTED    = 3'd0,
		ST_OVERWRITTEN = 3'd1,
		ST_FULL        = 3'd2,
		ST_FOUND       = 3'd3,
		ST_NOT_FOUND   = 3'd4,
		ST_REMOVED     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		OP_PUT    = 2'd0,
		OP_GET    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_MULT,
		S_READ,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

/* hdl/bht_req_if.sv */
interface bht_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [63:0] key;
	logic [3:0]  key_length;
	logic [63:0] value;
	modport source (output valid, opcode, key, key_length, value, input ready);
	modport sink (input valid, opcode, key, key_length, value, output ready);
endinterface

/* hdl/bht_rsp_if.sv */
interface bht_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] found_value;
	logic [10:0] entry_count;
	modport source (output valid, status, found_value, entry_count, input ready);
	modport sink (input valid, status, found_value, entry_count, output ready);
endinterface

/* hdl/bucketed_hash_table.sv */
// Bucketed hash table: set-associative store keyed by 1..8 byte keys.
// Channels: req (sink) carries opcode, key, key_length, value; rsp (source)
// returns status, found_value and entry_count, one response per request.
// The user must write index_bits through cfg_we/cfg_data only while the block
// is idle; the block itself does not enforce this. Steps: the shared hash
// adder folds in the key one byte at a time, then a multiply, then a memory
// read and a compare for each way of the bucket, then a write/response step.
// The block takes one request at a time; req.ready is high only in idle.
// Throughput is set by the way scan, a read and a compare per way, and by
// the byte-serial hash.
// Reset: a clearing pass walks all 2^MAX_INDEX_BITS * BUCKET_WAYS slots,
// one a cycle, before the first request is taken; configuration writes are
// taken during it.
// A stalled receiver holds the response in its register; the next request
// is taken and worked on, but waits in its last cycle until the response
// is delivered.
module bucketed_hash_table #(
	parameter int BUCKET_WAYS    = 4,
	parameter int MAX_INDEX_BITS = 8,
	parameter int KEY_BYTES      = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_data,
	bht_req_if.sink    req,
	bht_rsp_if.source  rsp
);

	localparam int WAY_W  = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
	localparam int SLOTS  = (1 << MAX_INDEX_BITS) * BUCKET_WAYS;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int LEN_W  = 4;
	localparam int BYTE_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
	localparam int ENTRY_W = 8 + LEN_W + 64 + 64;

	bht_pkg::state_t state_q, state_d;

	logic [3:0]          index_bits_q;
	logic [SLOT_W:0]     clr_cnt_q;
	logic [1:0]          op_q;
	logic [63:0]         key_q;
	logic [3:0]          len_q;
	logic [63:0]         val_q;
	logic [31:0]         hash_q;
	logic [BYTE_W:0]     byte_q;
	logic [WAY_W:0]      way_q;
	logic                match_q, empty_q;
	logic [WAY_W-1:0]    match_way_q, empty_way_q;
	logic [63:0]         match_val_q;
	logic [2:0]          status_q;
	logic [63:0]         found_q;
	logic [10:0]         count_q;
	logic                rsp_valid_q;

	// slot memory: valid bit in its own array, payload in another
	logic                mem_v [SLOTS];
	logic [ENTRY_W-1:0]  mem_e [SLOTS];
	logic                rd_v_q;
	logic [ENTRY_W-1:0]  rd_e_q;

	logic                we;
	logic [SLOT_W-1:0]   waddr, raddr;
	logic                wv;
	logic [ENTRY_W-1:0]  wdata;

	// clamp index_bits and key length
	logic [3:0] bits_c;
	always_comb begin
		bits_c = index_bits_q;
		if (bits_c == 4'd0) bits_c = 4'd1;
		if (32'(bits_c) > MAX_INDEX_BITS) bits_c = 4'(MAX_INDEX_BITS);
	end

	logic [3:0]  len_c;
	logic [63:0] key_c;
	always_comb begin
		len_c = req.key_length;
		if (len_c == 4'd0) len_c = 4'd1;
		if (32'(len_c) > KEY_BYTES) len_c = 4'(KEY_BYTES);
		key_c = req.key;
		for (int i = 0; i < 8; i++)
			if (i >= 32'(len_c)) key_c[8*i +: 8] = 8'd0;
	end

	// bucket address of the way being read; hash_q holds still from the scan on
	logic [MAX_INDEX_BITS-1:0] bucket_c;
	assign bucket_c = MAX_INDEX_BITS'(hash_q >> (6'd32 - 6'(bits_c)));
	logic [31:0] bucket_full;
	assign bucket_full = 32'(bucket_c);
	logic [WAY_W-1:0] way_idx;
	assign way_idx = way_q[WAY_W-1:0];
	assign raddr = SLOT_W'(bucket_full * BUCKET_WAYS + 32'(way_idx));

	// compare of the read way against the request
	logic hit_c;
	assign hit_c = rd_v_q && rd_e_q[ENTRY_W-1 -: 8] == hash_q[7:0]
		&& rd_e_q[ENTRY_W-9 -: LEN_W] == len_q && rd_e_q[127:64] == key_q;

	logic [7:0] byte_c;
	assign byte_c = key_q[8*byte_q[BYTE_W-1:0] +: 8];

	logic scan_last;
	assign scan_last = 32'(way_q) == BUCKET_WAYS - 1;

	// next state and memory write
	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = raddr;
		wv = 1'b0;
		wdata = '0;
		unique case (state_q)
			bht_pkg::S_CLEAR: begin
				we = 1'b1;
				waddr = clr_cnt_q[SLOT_W-1:0];
				if (32'(clr_cnt_q) == SLOTS - 1) state_d = bht_pkg::S_IDLE;
			end
			bht_pkg::S_IDLE:
				if (req.valid) state_d = bht_pkg::S_HASH;
			bht_pkg::S_HASH:
				if (byte_q + 1'b1 == (BYTE_W+1)'(len_q)) state_d = bht_pkg::S_MULT;
			bht_pkg::S_MULT: state_d = bht_pkg::S_READ;
			bht_pkg::S_READ: state_d = bht_pkg::S_SCAN;
			bht_pkg::S_SCAN:
				if (scan_last) begin
					state_d = bht_pkg::S_DONE;
				end else begin
					state_d = bht_pkg::S_READ;
				end
			bht_pkg::S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = bht_pkg::S_IDLE;
					waddr = SLOT_W'(bucket_full * BUCKET_WAYS);
					if (op_q == bht_pkg::OP_PUT && match_q) begin
						we = 1'b1;
						waddr = SLOT_W'(bucket_full * BUCKET_WAYS + 32'(match_way_q));
						wv = 1'b1;
						wdata = {hash_q[7:0], len_q, key_q, val_q};
					end else if (op_q == bht_pkg::OP_PUT && empty_q) begin
						we = 1'b1;
						waddr = SLOT_W'(bucket_full * BUCKET_WAYS + 32'(empty_way_q));
						wv = 1'b1;
						wdata = {hash_q[7:0], len_q, key_q, val_q};
					end else if (op_q == bht_pkg::OP_REMOVE && match_q) begin
						we = 1'b1;
						waddr = SLOT_W'(bucket_full * BUCKET_WAYS + 32'(match_way_q));
					end
				end
			end
			default: state_d = bht_pkg::S_IDLE;
		endcase
	end

	assign req.ready = (state_q == bht_pkg::S_IDLE);

	always_ff @(posedge clk) begin
		if (we) begin
			mem_v[waddr] <= wv;
			mem_e[waddr] <= wdata;
		end
		rd_v_q <= mem_v[raddr];
		rd_e_q <= mem_e[raddr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bht_pkg::S_CLEAR;
			index_bits_q <= 4'd4;
			clr_cnt_q <= '0;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) index_bits_q <= cfg_data;
			if (state_q == bht_pkg::S_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			if (state_q == bht_pkg::S_DONE && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
				if (op_q == bht_pkg::OP_PUT && !match_q && empty_q)
					count_q <= count_q + 1'b1;
				else if (op_q == bht_pkg::OP_REMOVE && match_q)
					count_q <= count_q - 1'b1;
			end
		end
	end

	// datapath: byte-serial hash, multiply, way scan, response status
	always_ff @(posedge clk) begin
		unique case (state_q)
			bht_pkg::S_IDLE: begin
				op_q <= req.opcode;
				key_q <= key_c;
				len_q <= len_c;
				val_q <= req.value;
				hash_q <= '0;
				byte_q <= '0;
			end
			bht_pkg::S_HASH: begin
				hash_q <= (hash_q << bht_pkg::HASH_STEP) + hash_q + 32'(byte_c);
				byte_q <= byte_q + 1'b1;
			end
			bht_pkg::S_MULT: begin
				hash_q <= hash_q * bht_pkg::HASH_MULT;
				way_q <= '0;
				match_q <= 1'b0;
				empty_q <= 1'b0;
				match_way_q <= '0;
				empty_way_q <= '0;
				match_val_q <= '0;
			end
			bht_pkg::S_SCAN: begin
				if (rd_v_q) begin
					if (!match_q && hit_c) begin
						match_q <= 1'b1;
						match_way_q <= way_idx;
						match_val_q <= rd_e_q[63:0];
					end
				end else if (!empty_q) begin
					empty_q <= 1'b1;
					empty_way_q <= way_idx;
				end
				way_q <= way_q + 1'b1;
			end
			bht_pkg::S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					found_q <= '0;
					unique case (op_q)
						bht_pkg::OP_PUT:
							status_q <= match_q ? bht_pkg::ST_OVERWRITTEN
								: empty_q ? bht_pkg::ST_INSERTED : bht_pkg::ST_FULL;
						bht_pkg::OP_GET: begin
							status_q <= match_q ? bht_pkg::ST_FOUND : bht_pkg::ST_NOT_FOUND;
							if (match_q) found_q <= match_val_q;
						end
						bht_pkg::OP_REMOVE:
							status_q <= match_q ? bht_pkg::ST_REMOVED : bht_pkg::ST_NOT_FOUND;
						default: status_q <= bht_pkg::ST_NOT_FOUND;
					endcase
				end
			end
			default: ;
		endcase
	end

	// count after this request
	logic [10:0] count_next;
	always_comb begin
		count_next = count_q;
		if (rsp_valid_q) count_next = count_q;
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.found_value = found_q;
	assign rsp.entry_count = count_next;

endmodule
